[rtl/mbps_pkg.sv]
// Shared package for the masked byte pattern search core.
// Holds field widths, register indexes, mode codes and the control structs
// passed from the top level to the signature and window cells.
package mbps_pkg;

   localparam int PATTERN_MAX_DEFAULT = 32;

   localparam int BYTE_W     = 8;
   localparam int IDX_W      = 5;
   localparam int LEN_W      = 6;
   localparam int ADDR_W     = 64;
   localparam int COUNT_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int OFF_W      = 6;
   localparam int SLOT_W     = 7;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_SCAN = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LENGTH = 2'd0,
      CSR_REGION_START   = 2'd1,
      CSR_REPORT_ALL     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic              shift_up;
      logic              shift_down;
      logic              load_en;
      logic [SLOT_W-1:0] load_slot;
      logic [BYTE_W-1:0] load_byte;
      logic              load_wild;
   } sig_ctl_type;

   typedef struct packed {
      logic             shift_en;
      logic             hit_load;
      logic [OFF_W-1:0] offset;
   } win_ctl_type;

endpackage

[rtl/mbps_if.sv]
// Valid/ready channel interfaces for the request and response transactions.
// Depends on mbps_pkg for the field widths.
interface mbps_req_if;
   import mbps_pkg::*;

   logic              valid;
   logic              ready;
   logic              mode;
   logic [IDX_W-1:0]  entry_index;
   logic [BYTE_W-1:0] byte_value;
   logic              is_wildcard;
   logic              last_byte;

   modport source (output valid, output mode, output entry_index, output byte_value,
                   output is_wildcard, output last_byte, input ready);
   modport sink   (input valid, input mode, input entry_index, input byte_value,
                   input is_wildcard, input last_byte, output ready);
endinterface

interface mbps_rsp_if;
   import mbps_pkg::*;

   logic              valid;
   logic              ready;
   logic              match_valid;
   logic [ADDR_W-1:0] match_address;
   logic              region_done;

   modport source (output valid, output match_valid, output match_address,
                   output region_done, input ready);
   modport sink   (input valid, input match_valid, input match_address,
                   input region_done, output ready);
endinterface

[rtl/mbps_sig_cell.sv]
// One signature slot: a pattern byte and its wildcard flag.
// Loads from the request or shifts to realign with the active length; uses mbps_pkg.
module mbps_sig_cell #(
   parameter int SLOT = 0
) (
   input  logic                           clock,
   input  mbps_pkg::sig_ctl_type          ctl,
   input  logic [mbps_pkg::BYTE_W-1:0]    lower_byte,
   input  logic                           lower_wild,
   input  logic [mbps_pkg::BYTE_W-1:0]    upper_byte,
   input  logic                           upper_wild,
   output logic [mbps_pkg::BYTE_W-1:0]    pat_byte,
   output logic                           pat_wild
);
   import mbps_pkg::*;

   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              wild_ff, wild_in;

   always_comb begin
      byte_in = byte_ff;
      wild_in = wild_ff;
      if (ctl.shift_up) begin
         byte_in = lower_byte;
         wild_in = lower_wild;
      end else if (ctl.shift_down) begin
         byte_in = upper_byte;
         wild_in = upper_wild;
      end else if (ctl.load_en && ctl.load_slot == SLOT_W'(SLOT)) begin
         byte_in = ctl.load_byte;
         wild_in = ctl.load_wild;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      wild_ff <= wild_in;
   end

   assign pat_byte = byte_ff;
   assign pat_wild = wild_ff;

endmodule

[rtl/mbps_win_cell.sv]
// One window slot: holds a scanned byte, passes it down the chain and
// registers whether the byte entering it matches the aligned signature slot; uses mbps_pkg.
module mbps_win_cell #(
   parameter int SLOT = 0
) (
   input  logic                           clock,
   input  mbps_pkg::win_ctl_type          ctl,
   input  logic [mbps_pkg::BYTE_W-1:0]    shift_byte,
   input  logic [mbps_pkg::BYTE_W-1:0]    pat_byte,
   input  logic                           pat_wild,
   output logic [mbps_pkg::BYTE_W-1:0]    win_byte,
   output logic                           hit
);
   import mbps_pkg::*;

   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              hit_ff, hit_in;

   always_comb begin
      byte_in = ctl.shift_en ? shift_byte : byte_ff;
      hit_in  = hit_ff;
      if (ctl.hit_load) begin
         hit_in = (OFF_W'(SLOT) < ctl.offset) || pat_wild || (shift_byte == pat_byte);
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      hit_ff  <= hit_in;
   end

   assign win_byte = byte_ff;
   assign hit      = hit_ff;

endmodule

[rtl/masked_byte_pattern_search_core.sv]
// Masked byte pattern search core: top level with the cell chains and result pipeline.
// A result passes through the s1, s2 and response registers on its way to rsp.
// Throughput: one transaction per cycle; on a response stall the response register and
// two pipeline stages hold back. After a pattern_length write, req.ready stays low while
// the signature chain shifts by the difference of the clamped old and new lengths.
// Reset (synchronous): pattern_length 1, region_start 0, report_all 0, signature undefined.
module masked_byte_pattern_search_core #(
   parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   mbps_req_if.sink                          req,
   mbps_rsp_if.source                        rsp,
   input  logic                              csr_write_enable,
   input  logic [mbps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import mbps_pkg::*;

   localparam int SIG_N = 2 * PATTERN_MAX - 1;
   localparam int LW    = LEN_W + 1;

   logic [LEN_W-1:0]   len_ff, len_in;
   logic [ADDR_W-1:0]  region_ff, region_in;
   logic               report_all_ff, report_all_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [COUNT_W-1:0] bytes_ff, bytes_in;
   logic               found_ff, found_in;

   logic               s1_v_ff, s1_v_in;
   logic [COUNT_W-1:0] s1_count_ff, s1_count_in;
   logic               s1_last_ff, s1_last_in;
   logic               s2_v_ff, s2_v_in;
   logic               s2_match_ff, s2_match_in;
   logic [COUNT_W-1:0] s2_offset_ff, s2_offset_in;
   logic               s2_last_ff, s2_last_in;
   logic               out_v_ff, out_v_in;
   logic               out_match_ff, out_match_in;
   logic [ADDR_W-1:0]  out_addr_ff, out_addr_in;
   logic               out_done_ff, out_done_in;

   logic [LW-1:0]      act_len;
   logic [OFF_W-1:0]   tgt_off;
   logic               aligned;
   logic               accept, scan, load;
   logic [COUNT_W-1:0] bs_inc;
   logic               out_free, report, emits, s1_go, s2_go;

   sig_ctl_type        sig_ctl;
   win_ctl_type        win_ctl;

   logic [BYTE_W-1:0]      sig_byte [SIG_N];
   logic                   sig_wild [SIG_N];
   logic [BYTE_W-1:0]      win_byte [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] hits;

   always_comb begin
      if (len_ff == '0) begin
         act_len = LW'(1);
      end else if (LW'(len_ff) > LW'(PATTERN_MAX)) begin
         act_len = LW'(PATTERN_MAX);
      end else begin
         act_len = LW'(len_ff);
      end
      tgt_off = OFF_W'(LW'(PATTERN_MAX) - act_len);
   end

   assign aligned  = (off_ff == tgt_off);
   assign accept   = req.valid && req.ready;
   assign scan     = accept && (req.mode == MODE_SCAN);
   assign load     = accept && (req.mode == MODE_LOAD) &&
                     (SLOT_W'(req.entry_index) < SLOT_W'(PATTERN_MAX));
   assign bs_inc   = (&bytes_ff) ? bytes_ff : bytes_ff + COUNT_W'(1);

   assign out_free = !out_v_ff || rsp.ready;
   assign report   = s2_match_ff && (report_all_ff || !found_ff);
   assign emits    = s2_v_ff && (report || s2_last_ff);
   assign s2_go    = !s2_v_ff || !emits || out_free;
   assign s1_go    = !s1_v_ff || s2_go;
   assign req.ready = s1_go && aligned;

   always_comb begin
      sig_ctl.shift_up   = off_ff < tgt_off;
      sig_ctl.shift_down = off_ff > tgt_off;
      sig_ctl.load_en    = load;
      sig_ctl.load_slot  = SLOT_W'(req.entry_index) + SLOT_W'(off_ff);
      sig_ctl.load_byte  = req.byte_value;
      sig_ctl.load_wild  = req.is_wildcard;
      win_ctl.shift_en   = scan;
      win_ctl.hit_load   = s1_go;
      win_ctl.offset     = off_ff;
   end

   for (genvar c = 0; c < SIG_N; c++) begin : g_sig
      logic [BYTE_W-1:0] lo_byte, hi_byte;
      logic              lo_wild, hi_wild;
      if (c == 0) begin : g_lo_end
         assign lo_byte = '0;
         assign lo_wild = 1'b0;
      end else begin : g_lo
         assign lo_byte = sig_byte[c-1];
         assign lo_wild = sig_wild[c-1];
      end
      if (c == SIG_N - 1) begin : g_hi_end
         assign hi_byte = '0;
         assign hi_wild = 1'b0;
      end else begin : g_hi
         assign hi_byte = sig_byte[c+1];
         assign hi_wild = sig_wild[c+1];
      end
      mbps_sig_cell #(.SLOT(c)) u_sig (
         .clock      (clock),
         .ctl        (sig_ctl),
         .lower_byte (lo_byte),
         .lower_wild (lo_wild),
         .upper_byte (hi_byte),
         .upper_wild (hi_wild),
         .pat_byte   (sig_byte[c]),
         .pat_wild   (sig_wild[c])
      );
   end

   for (genvar c = 0; c < PATTERN_MAX; c++) begin : g_win
      logic [BYTE_W-1:0] nb;
      if (c == PATTERN_MAX - 1) begin : g_top
         assign nb = req.byte_value;
      end else begin : g_mid
         assign nb = win_byte[c+1];
      end
      mbps_win_cell #(.SLOT(c)) u_win (
         .clock      (clock),
         .ctl        (win_ctl),
         .shift_byte (nb),
         .pat_byte   (sig_byte[c]),
         .pat_wild   (sig_wild[c]),
         .win_byte   (win_byte[c]),
         .hit        (hits[c])
      );
   end

   always_comb begin
      len_in        = len_ff;
      region_in     = region_ff;
      report_all_in = report_all_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_LENGTH: begin
               len_in = csr_write_data[LEN_W-1:0];
            end
            CSR_REGION_START: begin
               region_in = csr_write_data[ADDR_W-1:0];
            end
            CSR_REPORT_ALL: begin
               report_all_in = csr_write_data[0];
            end
            default: begin
               len_in = len_ff;
            end
         endcase
      end

      off_in = off_ff;
      if (sig_ctl.shift_up) begin
         off_in = off_ff + OFF_W'(1);
      end else if (sig_ctl.shift_down) begin
         off_in = off_ff - OFF_W'(1);
      end

      bytes_in = bytes_ff;
      if (scan) begin
         bytes_in = req.last_byte ? '0 : bs_inc;
      end

      s1_v_in     = s1_v_ff;
      s1_count_in = s1_count_ff;
      s1_last_in  = s1_last_ff;
      if (s1_go) begin
         s1_v_in     = scan;
         s1_count_in = bs_inc;
         s1_last_in  = req.last_byte;
      end

      s2_v_in      = s2_v_ff;
      s2_match_in  = s2_match_ff;
      s2_offset_in = s2_offset_ff;
      s2_last_in   = s2_last_ff;
      if (s2_go) begin
         s2_v_in      = s1_v_ff;
         s2_match_in  = (&hits) && (s1_count_ff >= COUNT_W'(act_len));
         s2_offset_in = s1_count_ff - COUNT_W'(act_len);
         s2_last_in   = s1_last_ff;
      end

      found_in = found_ff;
      if (s2_v_ff && s2_go) begin
         found_in = s2_last_ff ? 1'b0 : (found_ff || s2_match_ff);
      end

      out_v_in     = out_v_ff;
      out_match_in = out_match_ff;
      out_addr_in  = out_addr_ff;
      out_done_in  = out_done_ff;
      if (out_free) begin
         out_v_in = emits;
         if (emits) begin
            out_match_in = report;
            out_addr_in  = report ? region_ff + ADDR_W'(s2_offset_ff) : '0;
            out_done_in  = s2_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= LEN_W'(1);
         region_ff     <= '0;
         report_all_ff <= 1'b0;
         off_ff        <= OFF_W'(PATTERN_MAX - 1);
         bytes_ff      <= '0;
         found_ff      <= 1'b0;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         out_v_ff      <= 1'b0;
      end else begin
         len_ff        <= len_in;
         region_ff     <= region_in;
         report_all_ff <= report_all_in;
         off_ff        <= off_in;
         bytes_ff      <= bytes_in;
         found_ff      <= found_in;
         s1_v_ff       <= s1_v_in;
         s2_v_ff       <= s2_v_in;
         out_v_ff      <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_count_ff  <= s1_count_in;
      s1_last_ff   <= s1_last_in;
      s2_match_ff  <= s2_match_in;
      s2_offset_ff <= s2_offset_in;
      s2_last_ff   <= s2_last_in;
      out_match_ff <= out_match_in;
      out_addr_ff  <= out_addr_in;
      out_done_ff  <= out_done_in;
   end

   assign rsp.valid         = out_v_ff;
   assign rsp.match_valid   = out_match_ff;
   assign rsp.match_address = out_addr_ff;
   assign rsp.region_done   = out_done_ff;

endmodule

[rtl/mbps_checker.sv]
// Port-level checks for the masked byte pattern search core, with the bind
// that attaches them to the top level. Depends on mbps_pkg.
module mbps_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_match_valid,
   input logic [mbps_pkg::ADDR_W-1:0]     rsp_match_address,
   input logic                            rsp_region_done
);
   import mbps_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_match_valid) && $stable(rsp_match_address)
                                  && $stable(rsp_region_done))
      else $error("stalled response payload changed");

   a_rsp_has_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_match_valid || rsp_region_done)
      else $error("response carries neither a match nor region done");

   a_no_match_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_match_valid |-> rsp_match_address == '0)
      else $error("address nonzero on a response without a match");

endmodule

bind masked_byte_pattern_search_core mbps_checker u_mbps_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_match_valid   (rsp.match_valid),
   .rsp_match_address (rsp.match_address),
   .rsp_region_done   (rsp.region_done)
);
